>>> hdl/line_follow_wheel_duty_ramp_macros.svh
// Assertion macros for the line-follow wheel duty ramp block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef LINE_FOLLOW_WHEEL_DUTY_RAMP_MACROS_SVH
`define LINE_FOLLOW_WHEEL_DUTY_RAMP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low)
`define LFWDR_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("lfwdr: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define LFWDR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("lfwdr: assertion failed");

`else

`define LFWDR_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons)
`define LFWDR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)

`endif

`endif

>>> hdl/lfwdr_pkg.sv
// Package for the line-follow wheel duty ramp block: payload structs,
// duty constants, track codes and configuration register indexes.
// No dependencies.
`default_nettype none

package lfwdr_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Duties out of a PWM period of 40000
  localparam logic [15:0] PWM_PERIOD  = 16'd40000;
  localparam logic [15:0] RAMP_RESET  = 16'd5000;
  localparam logic [15:0] DUTY_CENTRE = 16'd5000;
  localparam logic [15:0] DUTY_SLOW   = 16'd3000;
  localparam logic [15:0] DUTY_MILD   = 16'd4000;

  localparam logic [1:0] BOARD_NONE = 2'd0;
  localparam logic [1:0] BOARD_ODD  = 2'd1;
  localparam logic [1:0] BOARD_EVEN = 2'd2;

  // Track sensor codes
  localparam logic [2:0] TRK_RAMP_RIGHT = 3'd1;
  localparam logic [2:0] TRK_CENTRE     = 3'd2;
  localparam logic [2:0] TRK_SLOW_LEFT  = 3'd3;
  localparam logic [2:0] TRK_RAMP_LEFT  = 3'd4;
  localparam logic [2:0] TRK_SLOW_RIGHT = 3'd6;
  localparam logic [2:0] TRK_PANEL      = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_CEIL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_CEIL     = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_SMALL_INTERVAL = 8'd3;
  localparam logic [7:0]  RST_LARGE_INTERVAL = 8'd2;
  localparam logic [15:0] RST_LONG_TICKS     = 16'd40;
  localparam logic [11:0] RST_SMALL_STEP     = 12'd300;
  localparam logic [11:0] RST_LARGE_STEP     = 12'd500;
  localparam logic [15:0] RST_SMALL_CEIL     = 16'd8000;
  localparam logic [15:0] RST_LARGE_CEIL     = 16'd13000;

  typedef struct packed {
    logic        toggle_run;
    logic [2:0]  track_code;
    logic [31:0] now_tick;
  } in_t;

  typedef struct packed {
    logic        left_on;
    logic [15:0] left_duty;
    logic        right_on;
    logic [15:0] right_duty;
    logic        board_done;
    logic [1:0]  board_number;
    logic        pause_request;
  } out_t;

endpackage

`default_nettype wire

>>> hdl/line_follow_wheel_duty_ramp.sv
// Line-follow wheel duty ramp: top level and only module.
// Depends on lfwdr_pkg and line_follow_wheel_duty_ramp_macros.svh.
`default_nettype none
`include "line_follow_wheel_duty_ramp_macros.svh"

// One transaction in is one control-loop pass and gives exactly one result.
// The block takes one transaction per cycle while out_ready takes each result.
// A result moves from the input register through one combinational pass into
// the result register. While a result waits for out_ready the input register
// can still take one transaction, after which in_ready stays low until the
// result is taken. The control state (run flag, cleaning mode,
// ramps, excursion and ramp ticks) updates as a pass moves into the result
// register, so successive passes see each other's effects with no gap.
// Configuration writes take effect at once and must only be made while no
// transaction is in flight.
module line_follow_wheel_duty_ramp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  lfwdr_pkg::in_t                 in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output lfwdr_pkg::out_t                      out_data,
  input  wire                                  cfg_we,
  input  wire  [lfwdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lfwdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lfwdr_pkg::*;

  // configuration
  logic [7:0]  small_int_r, large_int_r;
  logic [15:0] long_ticks_r;
  logic [11:0] small_step_r, large_step_r;
  logic [15:0] small_ceil_r, large_ceil_r;

  // pipeline
  in_t  in_q_r;
  logic in_vld_r;
  out_t out_q_r, res;
  logic out_vld_r;
  logic fire;

  // control state
  logic        running_r, running_nxt;
  logic        cleaning_r, cleaning_nxt;
  logic [15:0] ramp_l_r, ramp_l_nxt;
  logic [15:0] ramp_r_r, ramp_r_nxt;
  logic        need_start_r, need_start_nxt;
  logic [31:0] start_tick_r, start_tick_nxt;
  logic [31:0] last_tick_r, last_tick_nxt;
  logic        odd_r, odd_nxt;
  logic        held_l_on_r, held_l_on_nxt;
  logic [15:0] held_l_duty_r, held_l_duty_nxt;
  logic        held_r_on_r, held_r_on_nxt;
  logic [15:0] held_r_duty_r, held_r_duty_nxt;

  // ramp datapath
  logic [31:0] start_eff, age, since_step;
  logic        is_short, do_step;
  logic [7:0]  interval;
  logic [11:0] step;
  logic [15:0] ceil_raw, ceil_lim, ramp_sel, ramp_new;
  logic [16:0] ramp_sum;

  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  assign start_eff  = need_start_r ? in_q_r.now_tick : start_tick_r;
  assign age        = in_q_r.now_tick - start_eff;
  assign since_step = in_q_r.now_tick - last_tick_r;
  assign is_short   = age < {16'd0, long_ticks_r};
  assign interval   = is_short ? small_int_r  : large_int_r;
  assign step       = is_short ? small_step_r : large_step_r;
  assign ceil_raw   = is_short ? small_ceil_r : large_ceil_r;
  assign ceil_lim   = (ceil_raw > PWM_PERIOD) ? PWM_PERIOD : ceil_raw;
  assign do_step    = since_step >= {24'd0, interval};
  assign ramp_sel   = (in_q_r.track_code == TRK_RAMP_RIGHT) ? ramp_r_r : ramp_l_r;
  assign ramp_sum   = {1'b0, ramp_sel} + {5'd0, step};
  assign ramp_new   = (ramp_sum >= {1'b0, ceil_lim}) ? ceil_lim : ramp_sum[15:0];

  always_comb begin
    running_nxt     = running_r ^ in_q_r.toggle_run;
    cleaning_nxt    = cleaning_r;
    ramp_l_nxt      = ramp_l_r;
    ramp_r_nxt      = ramp_r_r;
    need_start_nxt  = need_start_r;
    start_tick_nxt  = start_tick_r;
    last_tick_nxt   = last_tick_r;
    odd_nxt         = odd_r;
    held_l_on_nxt   = held_l_on_r;
    held_l_duty_nxt = held_l_duty_r;
    held_r_on_nxt   = held_r_on_r;
    held_r_duty_nxt = held_r_duty_r;
    res             = '0;
    res.board_number = BOARD_NONE;

    if (!running_nxt) begin
      held_l_on_nxt   = 1'b0;
      held_l_duty_nxt = '0;
      held_r_on_nxt   = 1'b0;
      held_r_duty_nxt = '0;
    end else if (cleaning_r) begin
      // first running pass after a panel: drive off the board, then resume
      held_l_on_nxt     = 1'b1;
      held_l_duty_nxt   = DUTY_CENTRE;
      held_r_on_nxt     = 1'b1;
      held_r_duty_nxt   = DUTY_CENTRE;
      res.pause_request = 1'b1;
      cleaning_nxt      = 1'b0;
    end else begin
      case (in_q_r.track_code)
        TRK_CENTRE: begin
          ramp_l_nxt      = RAMP_RESET;
          ramp_r_nxt      = RAMP_RESET;
          need_start_nxt  = 1'b1;
          held_l_on_nxt   = 1'b1;
          held_l_duty_nxt = DUTY_CENTRE;
          held_r_on_nxt   = 1'b1;
          held_r_duty_nxt = DUTY_CENTRE;
        end
        TRK_SLOW_LEFT: begin
          held_l_on_nxt   = 1'b1;
          held_l_duty_nxt = DUTY_SLOW;
          held_r_on_nxt   = 1'b1;
          held_r_duty_nxt = DUTY_CENTRE;
        end
        TRK_SLOW_RIGHT: begin
          held_l_on_nxt   = 1'b1;
          held_l_duty_nxt = DUTY_CENTRE;
          held_r_on_nxt   = 1'b1;
          held_r_duty_nxt = DUTY_SLOW;
        end
        TRK_RAMP_RIGHT: begin
          need_start_nxt  = 1'b0;
          start_tick_nxt  = start_eff;
          held_l_on_nxt   = 1'b1;
          held_l_duty_nxt = is_short ? DUTY_MILD : DUTY_SLOW;
          held_r_on_nxt   = 1'b1;
          held_r_duty_nxt = ramp_r_r;
          if (do_step) begin
            ramp_r_nxt      = ramp_new;
            last_tick_nxt   = in_q_r.now_tick;
            held_r_duty_nxt = ramp_new;
          end
        end
        TRK_RAMP_LEFT: begin
          need_start_nxt  = 1'b0;
          start_tick_nxt  = start_eff;
          held_r_on_nxt   = 1'b1;
          held_r_duty_nxt = DUTY_SLOW;
          held_l_on_nxt   = 1'b1;
          held_l_duty_nxt = ramp_l_r;
          if (do_step) begin
            ramp_l_nxt      = ramp_new;
            last_tick_nxt   = in_q_r.now_tick;
            held_l_duty_nxt = ramp_new;
          end
        end
        TRK_PANEL: begin
          odd_nxt           = !odd_r;
          held_l_on_nxt     = 1'b0;
          held_l_duty_nxt   = '0;
          held_r_on_nxt     = 1'b0;
          held_r_duty_nxt   = '0;
          res.board_done    = 1'b1;
          res.board_number  = odd_nxt ? BOARD_ODD : BOARD_EVEN;
          res.pause_request = 1'b1;
          cleaning_nxt      = 1'b1;
        end
        default: begin
          // unknown code: outputs and ramps hold
        end
      endcase
    end

    res.left_on    = held_l_on_nxt;
    res.left_duty  = held_l_duty_nxt;
    res.right_on   = held_r_on_nxt;
    res.right_duty = held_r_duty_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_int_r  <= RST_SMALL_INTERVAL;
      large_int_r  <= RST_LARGE_INTERVAL;
      long_ticks_r <= RST_LONG_TICKS;
      small_step_r <= RST_SMALL_STEP;
      large_step_r <= RST_LARGE_STEP;
      small_ceil_r <= RST_SMALL_CEIL;
      large_ceil_r <= RST_LARGE_CEIL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMALL_INTERVAL: small_int_r  <= cfg_wdata[7:0];
        REG_LARGE_INTERVAL: large_int_r  <= cfg_wdata[7:0];
        REG_LONG_TICKS:     long_ticks_r <= cfg_wdata;
        REG_SMALL_STEP:     small_step_r <= cfg_wdata[11:0];
        REG_LARGE_STEP:     large_step_r <= cfg_wdata[11:0];
        REG_SMALL_CEIL:     small_ceil_r <= cfg_wdata;
        REG_LARGE_CEIL:     large_ceil_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline valids and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      running_r     <= 1'b0;
      cleaning_r    <= 1'b0;
      ramp_l_r      <= RAMP_RESET;
      ramp_r_r      <= RAMP_RESET;
      need_start_r  <= 1'b1;
      start_tick_r  <= '0;
      last_tick_r   <= '0;
      odd_r         <= 1'b0;
      held_l_on_r   <= 1'b0;
      held_l_duty_r <= '0;
      held_r_on_r   <= 1'b0;
      held_r_duty_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (fire) begin
        running_r     <= running_nxt;
        cleaning_r    <= cleaning_nxt;
        ramp_l_r      <= ramp_l_nxt;
        ramp_r_r      <= ramp_r_nxt;
        need_start_r  <= need_start_nxt;
        start_tick_r  <= start_tick_nxt;
        last_tick_r   <= last_tick_nxt;
        odd_r         <= odd_nxt;
        held_l_on_r   <= held_l_on_nxt;
        held_l_duty_r <= held_l_duty_nxt;
        held_r_on_r   <= held_r_on_nxt;
        held_r_duty_r <= held_r_duty_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
    if (fire) begin
      out_q_r <= res;
    end
  end

  `LFWDR_ASSERT_IMPL(a_panel_stops, clk, rst_n,
    out_vld_r && out_q_r.board_done,
    out_q_r.pause_request && !out_q_r.left_on && !out_q_r.right_on)
  `LFWDR_ASSERT_IMPL(a_board_num, clk, rst_n, out_vld_r,
    out_q_r.board_done == (out_q_r.board_number != BOARD_NONE))
  `LFWDR_ASSERT_NEXT(a_toggle, clk, rst_n, fire && in_q_r.toggle_run,
    running_r != $past(running_r))
  `LFWDR_ASSERT_NEXT(a_clean_exit, clk, rst_n, fire && running_nxt && cleaning_r,
    !cleaning_r && out_q_r.pause_request)
  `LFWDR_ASSERT_IMPL(a_ramp_bound, clk, rst_n, 1'b1,
    ramp_l_r <= PWM_PERIOD && ramp_r_r <= PWM_PERIOD)

endmodule

`default_nettype wire
